/* hdl/packet_ring_drop_oldest_defines.svh */
// assertion macros shared by the packet ring
// clocked on clk_i, disabled while rst_ni is low
`ifndef PACKET_RING_DROP_OLDEST_DEFINES_SVH
`define PACKET_RING_DROP_OLDEST_DEFINES_SVH

// condition must hold at every clock edge
`define PRDO_ASSERT_NOW(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PRDO_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/prdo_pkg.sv */
`default_nettype none

package prdo_pkg;

  // fixed field widths
  localparam int LEN_W  = 13;
  localparam int DROP_W = 12;

  // operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_PUSH_OK   = 2'd0,
    STATUS_PUSH_REJ  = 2'd1,
    STATUS_POPPED    = 2'd2,
    STATUS_POP_EMPTY = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PAD,
    S_EV_CHECK,
    S_HDR_A,
    S_HDR_B,
    S_HDR_C,
    S_EV_APPLY,
    S_FIT,
    S_WRITE,
    S_POP_HDR,
    S_POP_READ,
    S_POP_DATA,
    S_EMIT
  } state_e;

  // input beat
  typedef struct packed {
    logic             operation;
    logic [7:0]       data_byte;
    logic             first_of_packet;
    logic [LEN_W-1:0] packet_length;
  } in_item_t;

  // result beat
  typedef struct packed {
    status_e           status;
    logic [7:0]        popped_byte;
    logic              last_of_packet;
    logic [LEN_W-1:0]  popped_length;
    logic [DROP_W-1:0] dropped_packets;
    logic [LEN_W-1:0]  fill_level;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/prdo_ram.sv */
`default_nettype none

module prdo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/prdo_ring.sv */
`default_nettype none

module prdo_ring #(
  parameter int CAPACITY = 4096
) (
  input  wire logic [$clog2(CAPACITY)-1:0]   idx_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0] n_i,
  output logic      [$clog2(CAPACITY)-1:0]   sum_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [SW-1:0] raw;
  logic [SW-1:0] wrapped;

  // index plus step, wrapped once around the ring (step never exceeds capacity)
  always_comb begin
    raw     = SW'(idx_i) + SW'(n_i);
    wrapped = (raw >= SW'(CAPACITY)) ? (raw - SW'(CAPACITY)) : raw;
    sum_o   = wrapped[IW-1:0];
  end

endmodule

`default_nettype wire

/* hdl/packet_ring_drop_oldest.sv */
// Packet ring buffer that drops the oldest packets to make room.
// Input channel (in_valid_i / in_stall_o / in_item_i) carries one push or pop
// beat; each accepted beat yields exactly one result beat on the output channel
// (out_valid_o / out_stall_i / out_item_o), in order.
// Bytes sit in a single-port-write, single-port-read byte RAM; every pointer
// move goes through one shared ring adder, so work is sequenced one step per
// cycle and in_stall_o stays high until the current beat's result is issued.
// Work per beat: plain push bytes, stray bytes and empty pops go from decode
// to emit; a pop inside an open packet reads one byte between. A pop opening
// a packet first fetches the two header bytes and skips the header. A first
// push byte makes HEADER_BYTES+1 RAM writes after the space check, plus a zero
// byte per missing byte of an unfinished packet, plus an eviction step per
// packet dropped mid-read, or a header fetch and that step per packet dropped
// through its header. Eviction and pop cost are set by the one RAM read port.
// While the receiver stalls, the finished result is held in the output
// register; one more beat may be taken and worked up to its result, then no
// further beat is taken until the output register frees. Reset clears the
// pointers, the fill count and all packet state at once; the byte RAM is not
// cleared, so the block takes beats in the first cycle after reset.
`default_nettype none

`include "packet_ring_drop_oldest_defines.svh"

module packet_ring_drop_oldest #(
  parameter int CAPACITY     = 4096,
  parameter int HEADER_BYTES = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire prdo_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output prdo_pkg::out_item_t      out_item_o
);

  import prdo_pkg::*;

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = ((CW > LEN_W) ? CW : LEN_W) + 2;
  localparam int HCW = $clog2(HEADER_BYTES + 1);

  // control state
  state_e            state_q, state_d;
  logic [IW-1:0]     wr_q, wr_d;
  logic [IW-1:0]     rd_q, rd_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [LEN_W-1:0]  pop_rem_q, pop_rem_d;
  logic [LEN_W-1:0]  pop_len_q, pop_len_d;
  logic [LEN_W-1:0]  push_rem_q, push_rem_d;
  logic              rej_q, rej_d;
  logic              out_valid_q, out_valid_d;

  // working payload
  in_item_t          item_q, item_d;
  logic [7:0]        hdr_b0_q, hdr_b0_d;
  logic [4:0]        hdr_b1_q, hdr_b1_d;
  logic              hdr_pop_q, hdr_pop_d;
  logic [HCW-1:0]    cnt_q, cnt_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  status_e           res_status_q, res_status_d;
  logic [7:0]        res_byte_q, res_byte_d;
  logic              res_last_q, res_last_d;
  logic [LEN_W-1:0]  res_plen_q, res_plen_d;
  out_item_t         out_item_q, out_item_d;

  // shared ring adder
  logic [IW-1:0]     ring_idx;
  logic [CW-1:0]     ring_n;
  logic [IW-1:0]     ring_sum;

  // byte store ports
  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  // derived values
  logic              out_free;
  logic              in_fire;
  logic [XW-1:0]     occ_x;
  logic [XW-1:0]     free_x;
  logic [XW-1:0]     need_x;
  logic              no_room;
  logic [LEN_W-1:0]  hdr_len;
  logic [XW-1:0]     ev_raw_x;
  logic [XW-1:0]     ev_clip_x;
  logic              open_push;
  logic [IW-1:0]     pop_pos;

  prdo_ring #(
    .CAPACITY (CAPACITY)
  ) u_ring (
    .idx_i (ring_idx),
    .n_i   (ring_n),
    .sum_o (ring_sum)
  );

  prdo_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // handshake
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == S_IDLE) || ((state_q == S_EMIT) && out_free));
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // space and eviction arithmetic
  always_comb begin
    occ_x     = XW'(occ_q);
    free_x    = XW'(CAPACITY) - occ_x;
    need_x    = XW'(item_q.packet_length) + XW'(HEADER_BYTES);
    no_room   = free_x < need_x;
    hdr_len   = {hdr_b1_q, hdr_b0_q};
    ev_raw_x  = (pop_rem_q != '0) ? XW'(pop_rem_q) : (XW'(hdr_len) + XW'(HEADER_BYTES));
    ev_clip_x = (ev_raw_x > occ_x) ? occ_x : ev_raw_x;
    open_push = (push_rem_q != '0) && !rej_q;
    pop_pos   = (pop_rem_q != '0) ? rd_q : ring_sum;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    occ_d        = occ_q;
    pop_rem_d    = pop_rem_q;
    pop_len_d    = pop_len_q;
    push_rem_d   = push_rem_q;
    rej_d        = rej_q;
    out_valid_d  = out_valid_q && out_stall_i;
    item_d       = item_q;
    hdr_b0_d     = hdr_b0_q;
    hdr_b1_d     = hdr_b1_q;
    hdr_pop_d    = hdr_pop_q;
    cnt_d        = cnt_q;
    drop_d       = drop_q;
    res_status_d = res_status_q;
    res_byte_d   = res_byte_q;
    res_last_d   = res_last_q;
    res_plen_d   = res_plen_q;
    out_item_d   = out_item_q;
    ring_idx     = wr_q;
    ring_n       = CW'(1);
    ram_we       = 1'b0;
    ram_wdata    = item_q.data_byte;
    ram_re       = 1'b0;
    ram_raddr    = rd_q;

    unique case (state_q)
      S_IDLE: begin
        state_d = S_IDLE;
      end

      // decode the beat; simple cases finish here
      S_EXEC: begin
        res_byte_d = '0;
        res_last_d = 1'b0;
        res_plen_d = '0;
        if (item_q.operation == OP_PUSH) begin
          if (item_q.first_of_packet) begin
            if (!rej_q && (push_rem_q != '0)) begin
              state_d = S_PAD;
            end else begin
              rej_d      = 1'b0;
              push_rem_d = '0;
              state_d    = S_EV_CHECK;
            end
          end else if (push_rem_q == '0) begin
            res_status_d = STATUS_PUSH_REJ;
            state_d      = S_EMIT;
          end else if (rej_q) begin
            push_rem_d   = push_rem_q - LEN_W'(1);
            rej_d        = (push_rem_q != LEN_W'(1));
            res_status_d = STATUS_PUSH_REJ;
            state_d      = S_EMIT;
          end else begin
            ram_we       = 1'b1;
            wr_d         = ring_sum;
            push_rem_d   = push_rem_q - LEN_W'(1);
            res_status_d = STATUS_PUSH_OK;
            state_d      = S_EMIT;
          end
        end else begin
          ring_idx = rd_q;
          ring_n   = CW'(HEADER_BYTES);
          if (occ_q == '0) begin
            res_status_d = STATUS_POP_EMPTY;
            state_d      = S_EMIT;
          end else if (open_push && (pop_pos == wr_q)) begin
            res_status_d = STATUS_POP_EMPTY;
            state_d      = S_EMIT;
          end else if (pop_rem_q == '0) begin
            hdr_pop_d = 1'b1;
            state_d   = S_HDR_A;
          end else begin
            state_d = S_POP_READ;
          end
        end
      end

      // fill the unfinished packet with zero bytes
      S_PAD: begin
        ram_we     = 1'b1;
        ram_wdata  = '0;
        wr_d       = ring_sum;
        push_rem_d = push_rem_q - LEN_W'(1);
        if (push_rem_q == LEN_W'(1)) begin
          state_d = S_EV_CHECK;
        end
      end

      // evict oldest packets until the new one fits
      S_EV_CHECK: begin
        if (item_q.packet_length == '0) begin
          res_status_d = STATUS_PUSH_REJ;
          state_d      = S_EMIT;
        end else if (no_room && (occ_q != '0)) begin
          if (pop_rem_q != '0) begin
            state_d = S_EV_APPLY;
          end else begin
            hdr_pop_d = 1'b0;
            state_d   = S_HDR_A;
          end
        end else begin
          state_d = S_FIT;
        end
      end

      // header fetch: two reads through the one read port
      S_HDR_A: begin
        ram_re    = 1'b1;
        ram_raddr = rd_q;
        state_d   = S_HDR_B;
      end

      S_HDR_B: begin
        ring_idx  = rd_q;
        ring_n    = CW'(1);
        ram_re    = 1'b1;
        ram_raddr = ring_sum;
        hdr_b0_d  = ram_rdata;
        state_d   = S_HDR_C;
      end

      S_HDR_C: begin
        hdr_b1_d = ram_rdata[4:0];
        state_d  = hdr_pop_q ? S_POP_HDR : S_EV_APPLY;
      end

      // drop one packet, whole or its unread rest
      S_EV_APPLY: begin
        ring_idx  = rd_q;
        ring_n    = ev_clip_x[CW-1:0];
        rd_d      = ring_sum;
        occ_d     = occ_q - ev_clip_x[CW-1:0];
        pop_rem_d = '0;
        pop_len_d = '0;
        drop_d    = drop_q + DROP_W'(1);
        state_d   = S_EV_CHECK;
      end

      // reject or start the header write
      S_FIT: begin
        if (no_room) begin
          push_rem_d   = item_q.packet_length - LEN_W'(1);
          rej_d        = (item_q.packet_length != LEN_W'(1));
          res_status_d = STATUS_PUSH_REJ;
          state_d      = S_EMIT;
        end else begin
          cnt_d   = '0;
          state_d = S_WRITE;
        end
      end

      // length header little-endian, then the first data byte
      S_WRITE: begin
        ram_we = 1'b1;
        wr_d   = ring_sum;
        cnt_d  = cnt_q + HCW'(1);
        if (cnt_q == HCW'(HEADER_BYTES)) begin
          ram_wdata    = item_q.data_byte;
          occ_d        = occ_q + need_x[CW-1:0];
          push_rem_d   = item_q.packet_length - LEN_W'(1);
          res_status_d = STATUS_PUSH_OK;
          state_d      = S_EMIT;
        end else if (cnt_q == HCW'(0)) begin
          ram_wdata = item_q.packet_length[7:0];
        end else if (cnt_q == HCW'(1)) begin
          ram_wdata = {3'b000, item_q.packet_length[LEN_W-1:8]};
        end else begin
          ram_wdata = '0;
        end
      end

      // open a packet for reading: skip its header
      S_POP_HDR: begin
        ring_idx  = rd_q;
        ring_n    = CW'(HEADER_BYTES);
        rd_d      = ring_sum;
        occ_d     = (occ_q >= CW'(HEADER_BYTES)) ? (occ_q - CW'(HEADER_BYTES)) : '0;
        pop_rem_d = (hdr_len == '0) ? LEN_W'(1) : hdr_len;
        pop_len_d = (hdr_len == '0) ? LEN_W'(1) : hdr_len;
        state_d   = S_POP_READ;
      end

      S_POP_READ: begin
        ring_idx  = rd_q;
        ring_n    = CW'(1);
        ram_re    = 1'b1;
        ram_raddr = rd_q;
        rd_d      = ring_sum;
        occ_d     = (occ_q != '0) ? (occ_q - CW'(1)) : '0;
        pop_rem_d = pop_rem_q - LEN_W'(1);
        state_d   = S_POP_DATA;
      end

      S_POP_DATA: begin
        res_byte_d   = ram_rdata;
        res_last_d   = (pop_rem_q == '0);
        res_plen_d   = pop_len_q;
        res_status_d = STATUS_POPPED;
        if (pop_rem_q == '0) begin
          pop_len_d = '0;
        end
        state_d = S_EMIT;
      end

      // hand the result to the output register
      S_EMIT: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_item_d.status          = res_status_q;
          out_item_d.popped_byte     = res_byte_q;
          out_item_d.last_of_packet  = res_last_q;
          out_item_d.popped_length   = res_plen_q;
          out_item_d.dropped_packets = drop_q;
          out_item_d.fill_level      = LEN_W'(occ_x);
          state_d                    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // take a new beat
    if (in_fire) begin
      item_d  = in_item_i;
      drop_d  = '0;
      state_d = S_EXEC;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      occ_q       <= '0;
      pop_rem_q   <= '0;
      pop_len_q   <= '0;
      push_rem_q  <= '0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      occ_q       <= occ_d;
      pop_rem_q   <= pop_rem_d;
      pop_len_q   <= pop_len_d;
      push_rem_q  <= push_rem_d;
      rej_q       <= rej_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    hdr_b0_q     <= hdr_b0_d;
    hdr_b1_q     <= hdr_b1_d;
    hdr_pop_q    <= hdr_pop_d;
    cnt_q        <= cnt_d;
    drop_q       <= drop_d;
    res_status_q <= res_status_d;
    res_byte_q   <= res_byte_d;
    res_last_q   <= res_last_d;
    res_plen_q   <= res_plen_d;
    out_item_q   <= out_item_d;
  end

  // checks
  `PRDO_ASSERT_NOW(a_occ_in_range, occ_q <= CW'(CAPACITY), "fill count above capacity")
  `PRDO_ASSERT_NOW(a_reject_has_rest, !rej_q || (push_rem_q != '0), "rejecting with no bytes left")
  `PRDO_ASSERT_NEXT(a_accept_decodes, in_valid_i && !in_stall_o, state_q == S_EXEC, "accepted beat not decoded")
  `PRDO_ASSERT_NEXT(a_emit_loads, (state_q == S_EMIT) && out_free, out_valid_q, "result not loaded")

endmodule

`default_nettype wire
